[rtl/trt_pkg.sv]
// shared types and constants for the table revision tracker
// used by trt_row_logic and table_revision_tracker_core; no dependencies
package trt_pkg;

    // defaults for the top level parameters
    localparam int DEF_NUM_SUBTYPES = 7;
    localparam int DEF_MAX_SECTIONS = 256;

    // field widths
    localparam int SUBTYPE_W = 4;
    localparam int BYTE_W    = 8;
    localparam int VER_W     = 5;

    // stream word widths; the tdata widths are padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;

    // protocol constants
    localparam logic [VER_W-1:0]  TOP_VERSION = 5'd31;
    localparam logic [BYTE_W-1:0] GOOD_LENGTH = 8'd3;

    // item kind carried in tuser
    typedef enum logic {
        ACT_DESCRIPTOR = 1'b0,
        ACT_RESTART    = 1'b1
    } t_action;

    // one registered input word
    typedef struct packed {
        t_action               action;
        logic [SUBTYPE_W-1:0]  table_subtype;
        logic [BYTE_W-1:0]     descriptor_length;
        logic [BYTE_W-1:0]     version_byte;
        logic [BYTE_W-1:0]     section_number;
        logic [BYTE_W-1:0]     last_section_number;
    } t_in_word;

    // status from the row update logic
    typedef struct packed {
        logic new_version;
        logic first_seen;
        logic row_empty;
    } t_row_flags;

endpackage

[rtl/trt_row_logic.sv]
// next-state logic for one subtype row: version compare, bitmap fill,
// section check and clear, and row emptiness; depends on trt_pkg
module trt_row_logic #(
    parameter int MAX_SECTIONS = trt_pkg::DEF_MAX_SECTIONS
) (
    input  logic                        i_valid,
    input  logic [trt_pkg::VER_W-1:0]   i_cur_version,
    input  logic [MAX_SECTIONS-1:0]     i_map,
    input  logic [trt_pkg::VER_W-1:0]   i_version,
    input  logic [trt_pkg::BYTE_W-1:0]  i_section,
    input  logic [trt_pkg::BYTE_W-1:0]  i_last_section,
    output logic [MAX_SECTIONS-1:0]     o_map,
    output trt_pkg::t_row_flags         o_flags
);
    import trt_pkg::*;

    localparam int SEC_W = $clog2(MAX_SECTIONS);

    logic                    w_newer;
    logic [MAX_SECTIONS-1:0] w_fill;
    logic [MAX_SECTIONS-1:0] w_base;
    logic                    w_in_range;
    logic                    w_hit;
    logic [SEC_W-1:0]        w_idx;

    // newer when unseen, greater, or wrapping down from the top version
    assign w_newer = !i_valid || (i_version > i_cur_version) ||
                     ((i_cur_version == TOP_VERSION) && (i_version < i_cur_version));

    // sections 0 to last become unseen on a new version
    always_comb begin
        for (int s = 0; s < MAX_SECTIONS; s++) begin
            w_fill[s] = (9'(s) <= {1'b0, i_last_section});
        end
    end

    assign w_base     = w_newer ? w_fill : i_map;
    assign w_in_range = ({1'b0, i_section} < 9'(MAX_SECTIONS));
    assign w_idx      = i_section[SEC_W-1:0];
    assign w_hit      = w_in_range && w_base[w_idx];

    // clear the section bit when it was unseen
    always_comb begin
        o_map = w_base;
        if (w_hit) begin
            o_map[w_idx] = 1'b0;
        end
    end

    assign o_flags.new_version = w_newer;
    assign o_flags.first_seen  = w_hit;
    assign o_flags.row_empty   = ~|o_map;

endmodule

[rtl/table_revision_tracker_core.sv]
// top level of the table revision tracker: input register, state rows,
// ready flag and result register; depends on trt_pkg and trt_row_logic
//
//  channel   | direction | tdata                                   | tuser
//  ----------+-----------+-----------------------------------------+--------
//  s_axis    | in        | subtype, length, version, section, last | action
//  m_axis    | out       | accepted, new_version, first, ready     | -
//
// one word per cycle sustained while the output is not stalled; a word
// passes the input register, then the result register; the whole update of
// one subtype row and the all-rows empty check sit between those two.
// synchronous reset and the restart action both clear every row at once.
// a stalled output holds the result; the input register keeps taking words
// as long as the result register can move.
module table_revision_tracker_core #(
    parameter int NUM_SUBTYPES = trt_pkg::DEF_NUM_SUBTYPES,
    parameter int MAX_SECTIONS = trt_pkg::DEF_MAX_SECTIONS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [3:0] table_subtype, [11:4] descriptor_length, [19:12] version_byte,
    // [27:20] section_number, [35:28] last_section_number, [39:36] zero
    input  logic [trt_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] action
    input  logic [trt_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] accepted, [1] new_version, [2] section_first_seen, [3] ready_res,
    // [7:4] zero
    output logic [trt_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import trt_pkg::*;

    localparam int SUB_W = (NUM_SUBTYPES > 1) ? $clog2(NUM_SUBTYPES) : 1;

    // input register
    logic      r_in_valid;
    t_in_word  r_in;

    // tracking state
    logic                    r_ver_valid [NUM_SUBTYPES];
    logic [VER_W-1:0]        r_version   [NUM_SUBTYPES];
    logic [MAX_SECTIONS-1:0] r_map       [NUM_SUBTYPES];
    logic                    r_ready;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_out;

    logic                    w_advance;
    logic                    w_restart;
    logic                    w_acc;
    logic [SUBTYPE_W-1:0]    w_sub_minus1;
    logic [SUB_W-1:0]        w_idx;
    logic                    w_others_busy;
    logic [MAX_SECTIONS-1:0] w_new_map;
    t_row_flags              w_flags;
    logic                    n_ready;
    t_in_word                w_in_word;

    // handshake: the input register moves when the result register can load
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out};

    // unpack the incoming word
    assign w_in_word.action              = t_action'(i_s_axis_tuser[0]);
    assign w_in_word.table_subtype       = i_s_axis_tdata[3:0];
    assign w_in_word.descriptor_length   = i_s_axis_tdata[11:4];
    assign w_in_word.version_byte        = i_s_axis_tdata[19:12];
    assign w_in_word.section_number      = i_s_axis_tdata[27:20];
    assign w_in_word.last_section_number = i_s_axis_tdata[35:28];

    // descriptor checks
    assign w_restart    = (r_in.action == ACT_RESTART);
    assign w_sub_minus1 = r_in.table_subtype - 4'd1;
    assign w_idx        = w_sub_minus1[SUB_W-1:0];
    assign w_acc        = !w_restart && !r_ready &&
                          (r_in.descriptor_length == GOOD_LENGTH) &&
                          (r_in.table_subtype != 4'd0) &&
                          (r_in.table_subtype <= SUBTYPE_W'(NUM_SUBTYPES));

    // row update for the addressed subtype
    trt_row_logic #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_row (
        .i_valid        (r_ver_valid[w_idx]),
        .i_cur_version  (r_version[w_idx]),
        .i_map          (r_map[w_idx]),
        .i_version      (r_in.version_byte[VER_W-1:0]),
        .i_section      (r_in.section_number),
        .i_last_section (r_in.last_section_number),
        .o_map          (w_new_map),
        .o_flags        (w_flags)
    );

    // any other subtype still waiting on sections
    always_comb begin
        w_others_busy = 1'b0;
        for (int u = 0; u < NUM_SUBTYPES; u++) begin
            if ((SUB_W'(u) != w_idx) && (|r_map[u])) begin
                w_others_busy = 1'b1;
            end
        end
    end

    // ready flag after this word
    always_comb begin
        n_ready = r_ready;
        if (w_restart) begin
            n_ready = 1'b0;
        end else if (w_acc) begin
            if (w_flags.new_version) begin
                n_ready = 1'b0;
            end
            if (w_flags.first_seen && w_flags.row_empty && !w_others_busy) begin
                n_ready = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ready     <= 1'b0;
            for (int u = 0; u < NUM_SUBTYPES; u++) begin
                r_ver_valid[u] <= 1'b0;
                r_version[u]   <= '0;
                r_map[u]       <= '0;
            end
        end else begin
            // input register
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    r_in <= w_in_word;
                end
            end

            // result register
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_out       <= {n_ready,
                                w_acc && w_flags.first_seen,
                                w_acc && w_flags.new_version,
                                w_acc};
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // tracking state
            if (w_advance) begin
                r_ready <= n_ready;
                if (w_restart) begin
                    for (int u = 0; u < NUM_SUBTYPES; u++) begin
                        r_ver_valid[u] <= 1'b0;
                        r_version[u]   <= '0;
                        r_map[u]       <= '0;
                    end
                end else if (w_acc) begin
                    r_map[w_idx] <= w_new_map;
                    if (w_flags.new_version) begin
                        r_ver_valid[w_idx] <= 1'b1;
                        r_version[w_idx]   <= r_in.version_byte[VER_W-1:0];
                    end
                end
            end
        end
    end

    // ready only drops through a restart
    a_ready_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready && !(w_advance && w_restart)) |=> r_ready)
        else $error("ready flag dropped without restart");

    // a new version or first sighting is only reported on an accepted word
    a_flags_need_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out[0]) |-> (!r_out[1] && !r_out[2]))
        else $error("result flag without accepted descriptor");

    // a restart leaves no ready flag and no accepted result
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_restart) |=> (!r_ready && r_out_valid && (r_out == 4'd0)))
        else $error("restart did not clear tracking");

    // a waiting input word is not lost while the output stalls
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input word dropped under stall");

endmodule
